// ----- hdl/nsfc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsfc_pkg
// Shared types and codes of the nearest sample feedback controller.
// ----------------------------------------------------------------------------
package nsfc_pkg;

	localparam int VAL_W = 16;
	localparam int DIST_W = 21;
	localparam int ACC_W = 40;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_PUSH  = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	localparam logic [1:0] REG_MIN_0 = 2'd0;
	localparam logic [1:0] REG_MAX_0 = 2'd1;
	localparam logic [1:0] REG_MIN_1 = 2'd2;
	localparam logic [1:0] REG_MAX_1 = 2'd3;

	typedef struct packed {
		logic clr_count;
		logic push;
		logic wr_word;
		logic wr_query;
		logic scan_start;
		logic scan_step;
		logic fb_clear;
		logic fb_step;
		logic emit;
	} ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic scan_last;
		logic fb_last;
	} stat_t;

endpackage
`default_nettype wire

// ----- hdl/nsfc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsfc_ctrl
// Sequencer: table writes, distance scan, feedback multiply-accumulate, output.
// ----------------------------------------------------------------------------
module nsfc_ctrl #(
	parameter int ACT_DIM = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [1:0]     kind,
	input  wire logic           last,
	input  wire nsfc_pkg::stat_t st,
	output logic                busy,
	output nsfc_pkg::ctrl_t     cmd,
	output logic                act_sel,
	output logic                def_mode
);
	import nsfc_pkg::*;

	localparam logic LAST_ACT = 1'(ACT_DIM - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN0, S_SCAN, S_DRAIN, S_FB, S_FBW, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0] drain_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.clr_count = start && !busy && kind == KIND_CLEAR;
		cmd.wr_word = start && !busy && kind == KIND_WRITE && !st.full;
		cmd.push = start && !busy && kind == KIND_PUSH && !st.full;
		cmd.wr_query = start && !busy && kind == KIND_QUERY;
		cmd.scan_start = cmd.wr_query && last && !st.empty;
		cmd.scan_step = (state_q == S_SCAN0) || (state_q == S_SCAN);
		cmd.fb_clear = (state_q == S_DRAIN) && drain_q == 2'd0;
		cmd.fb_step = (state_q == S_FB);
		cmd.emit = (state_q == S_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drain_q <= '0;
			act_sel <= 1'b0;
			def_mode <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					act_sel <= 1'b0;
					if (cmd.wr_query && last) begin
						def_mode <= st.empty;
						state_q <= st.empty ? S_OUT : S_SCAN0;
					end
				end
				S_SCAN0: begin
					if (st.scan_last) begin
						state_q <= S_DRAIN;
						drain_q <= 2'd3;
					end else state_q <= S_SCAN;
				end
				S_SCAN: if (st.scan_last) begin
					state_q <= S_DRAIN;
					drain_q <= 2'd3;
				end
				S_DRAIN: begin
					if (drain_q == 2'd0) state_q <= S_FB;
					else drain_q <= drain_q - 2'd1;
				end
				S_FB: if (st.fb_last) begin
					state_q <= S_FBW;
					drain_q <= 2'd3;
				end
				S_FBW: begin
					if (drain_q == 2'd0) state_q <= S_OUT;
					else drain_q <= drain_q - 2'd1;
				end
				S_OUT: begin
					act_sel <= ~act_sel;
					if (act_sel == LAST_ACT) state_q <= S_IDLE;
					else if (def_mode) state_q <= S_OUT;
					else state_q <= S_FB;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hdl/nsfc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nsfc_dp
// Sample memories, L1 distance scan and feedback multiply-accumulate.
// ----------------------------------------------------------------------------
module nsfc_dp #(
	parameter int SAMPLES = 64,
	parameter int STATE_DIM = 4,
	parameter int ACT_DIM = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire nsfc_pkg::ctrl_t      cmd,
	input  wire logic                 act_sel,
	input  wire logic                 def_mode,
	input  wire logic [3:0]           word_index,
	input  wire logic signed [15:0]   value,
	input  wire logic signed [15:0]   lo0,
	input  wire logic signed [15:0]   hi0,
	input  wire logic signed [15:0]   lo1,
	input  wire logic signed [15:0]   hi1,
	output nsfc_pkg::stat_t           st,
	output logic                      res_valid,
	output logic                      res_index,
	output logic signed [15:0]        res_action,
	output logic [5:0]                res_sample,
	output logic                      res_default,
	output logic                      res_last
);
	import nsfc_pkg::*;

	localparam int IW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int CW = $clog2(SAMPLES + 1);
	localparam int SW = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
	localparam int AW = (ACT_DIM > 1) ? $clog2(ACT_DIM) : 1;
	localparam int GD = ACT_DIM * STATE_DIM;
	localparam int GW = (GD > 1) ? $clog2(GD) : 1;

	logic signed [15:0] pmem [SAMPLES*STATE_DIM];
	logic signed [15:0] amem [SAMPLES*ACT_DIM];
	logic signed [15:0] gmem [SAMPLES*GD];
	logic signed [15:0] qv_q [STATE_DIM];
	logic [CW-1:0] count_q;

	logic [IW-1:0] si_q, best_q, cur_s1, cur_s2;
	logic [SW-1:0] se_q, fe_q;
	logic          sv_s1, sv_s2, first_s1, first_s2, seen_q, lastel_s1, lastel_s2;
	logic signed [15:0] pt_s1, q_s1;
	logic [DIST_W-1:0] dacc_q, best_d_q, dsum;
	logic signed [15:0] fp_s1, fg_s1, fq_s1, fa_q;
	logic signed [16:0] dx_s2, fdx_s2;
	logic signed [15:0] g_s2;
	logic signed [32:0] prod_s3;
	logic fv_s1, fv_s2, fv_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic [IW+SW-1:0] paddr_w;
	logic [CW-1:0] slotc;

	assign slotc = count_q;
	assign st.empty = (count_q == '0);
	assign st.full = (count_q >= CW'(SAMPLES));
	assign st.scan_last = cmd.scan_step && se_q == SW'(STATE_DIM-1)
		&& (CW'(si_q) + CW'(1)) == count_q;
	assign st.fb_last = cmd.fb_step && fe_q == SW'(STATE_DIM-1);

	// table writes
	always_ff @(posedge clk) begin
		if (cmd.wr_word) begin
			if (word_index < 4'(STATE_DIM))
				pmem[(IW+SW)'(slotc[IW-1:0]*STATE_DIM + word_index[SW-1:0])] <= value;
			else if (word_index < 4'(STATE_DIM+ACT_DIM))
				amem[(IW+AW)'(slotc[IW-1:0]*ACT_DIM
					+ AW'(word_index - 4'(STATE_DIM)))] <= value;
			else if (word_index < 4'(STATE_DIM+ACT_DIM+GD))
				gmem[(IW+GW)'(slotc[IW-1:0]*GD
					+ GW'(word_index - 4'(STATE_DIM+ACT_DIM)))] <= value;
		end
		if (cmd.wr_query && word_index < 4'(STATE_DIM))
			qv_q[word_index[SW-1:0]] <= value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cmd.clr_count) count_q <= '0;
		else if (cmd.push) count_q <= count_q + CW'(1);
	end

	// scan: one point element per cycle
	assign paddr_w = (IW+SW)'(si_q * STATE_DIM + se_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			si_q <= '0; se_q <= '0; sv_s1 <= 1'b0; sv_s2 <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				si_q <= '0; se_q <= '0;
			end else if (cmd.scan_step) begin
				if (se_q == SW'(STATE_DIM-1)) begin
					se_q <= '0; si_q <= si_q + IW'(1);
				end else se_q <= se_q + SW'(1);
			end
			sv_s1 <= cmd.scan_step;
			sv_s2 <= sv_s1;
		end
	end

	always_ff @(posedge clk) begin
		pt_s1 <= pmem[paddr_w];
		q_s1 <= qv_q[se_q];
		cur_s1 <= si_q;
		first_s1 <= (se_q == '0);
		lastel_s1 <= (se_q == SW'(STATE_DIM-1));
		cur_s2 <= cur_s1;
		first_s2 <= first_s1;
		lastel_s2 <= lastel_s1;
		dx_s2 <= 17'(q_s1) - 17'(pt_s1);
	end

	assign dsum = (first_s2 ? '0 : dacc_q)
		+ DIST_W'(dx_s2[16] ? -dx_s2 : dx_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seen_q <= 1'b0;
		else if (cmd.scan_start) seen_q <= 1'b0;
		else if (sv_s2 && lastel_s2) seen_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (sv_s2) begin
			dacc_q <= dsum;
			if (lastel_s2 && (!seen_q || dsum < best_d_q)) begin
				best_d_q <= dsum;
				best_q <= cur_s2;
			end
		end
	end

	// feedback: one gain product per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q <= '0; fv_s1 <= 1'b0; fv_s2 <= 1'b0; fv_s3 <= 1'b0;
		end else begin
			if (cmd.fb_clear || cmd.emit) fe_q <= '0;
			else if (cmd.fb_step) fe_q <= fe_q + SW'(1);
			fv_s1 <= cmd.fb_step;
			fv_s2 <= fv_s1;
			fv_s3 <= fv_s2;
		end
	end

	always_ff @(posedge clk) begin
		fp_s1 <= pmem[(IW+SW)'(best_q * STATE_DIM + fe_q)];
		fg_s1 <= gmem[(IW+GW)'(best_q*GD + act_sel*STATE_DIM + fe_q)];
		fq_s1 <= qv_q[fe_q];
		fa_q <= amem[(IW+AW)'(best_q*ACT_DIM + act_sel)];
		g_s2 <= fg_s1;
		fdx_s2 <= 17'(fp_s1) - 17'(fq_s1);
		prod_s3 <= 33'(g_s2) * 33'(fdx_s2);
		if (cmd.fb_clear || cmd.emit) acc_q <= '0;
		else if (fv_s3) acc_q <= acc_q + ACC_W'(prod_s3);
	end

	// result
	logic signed [ACC_W-1:0] v;
	logic signed [16:0] lo, hi, dflt;
	logic signed [ACC_W-1:0] vc;
	always_comb begin
		lo = act_sel ? 17'(lo1) : 17'(lo0);
		hi = act_sel ? 17'(hi1) : 17'(hi0);
		dflt = (hi - lo) >>> 1;
		v = ACC_W'(fa_q) + (acc_q >>> 8);
		vc = v;
		if (vc < ACC_W'(lo)) vc = ACC_W'(lo);
		if (vc > ACC_W'(hi)) vc = ACC_W'(hi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else res_valid <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		res_index <= act_sel;
		res_action <= def_mode ? dflt[15:0] : vc[15:0];
		res_sample <= def_mode ? 6'd0 : 6'(best_q);
		res_default <= def_mode;
		res_last <= (AW'(act_sel) == AW'(ACT_DIM-1));
	end
endmodule
`default_nettype wire

// ----- hdl/nearest_sample_feedback_control.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_sample_feedback_control
// Nearest-sample gain-scheduled state feedback with an APB limit port.
// ----------------------------------------------------------------------------
// Clear, write, push and non-final query words do not raise busy. A final query
// word on a non-empty table scans one point element per cycle over the stored
// samples, waits in S_DRAIN for the scan pipeline, then for each action runs
// STATE_DIM multiply steps in S_FB, waits in S_FBW for the multiply pipeline
// and emits the action in S_OUT. On an empty table the two default actions are
// emitted without a scan. busy falls in the cycle the last action is strobed on
// done; results cannot be stalled by the receiver.
module nearest_sample_feedback_control #(
	parameter int SAMPLES = 64,
	parameter int STATE_DIM = 4,
	parameter int ACT_DIM = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         kind,
	input  wire logic [3:0]         word_index,
	input  wire logic signed [15:0] value,
	input  wire logic               last,
	output logic                    done,
	output logic                    action_index,
	output logic signed [15:0]      action,
	output logic [5:0]              nearest_sample,
	output logic                    used_default,
	output logic                    last_result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import nsfc_pkg::*;

	ctrl_t cmd;
	stat_t st;
	logic act_sel, def_mode;
	logic signed [15:0] lo0_q, hi0_q, lo1_q, hi1_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo0_q <= 16'sh8000; hi0_q <= 16'sh7fff;
			lo1_q <= 16'sh8000; hi1_q <= 16'sh7fff;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_MIN_0: lo0_q <= pwdata[15:0];
				REG_MAX_0: hi0_q <= pwdata[15:0];
				REG_MIN_1: lo1_q <= pwdata[15:0];
				REG_MAX_1: hi1_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MIN_0: prdata = 32'(lo0_q);
			REG_MAX_0: prdata = 32'(hi0_q);
			REG_MIN_1: prdata = 32'(lo1_q);
			REG_MAX_1: prdata = 32'(hi1_q);
			default: prdata = '0;
		endcase
	end

	nsfc_ctrl #(.ACT_DIM(ACT_DIM)) u_ctrl (
		.clk, .arst_n, .start, .kind, .last, .st, .busy, .cmd, .act_sel, .def_mode
	);

	nsfc_dp #(.SAMPLES(SAMPLES), .STATE_DIM(STATE_DIM), .ACT_DIM(ACT_DIM)) u_dp (
		.clk, .arst_n, .cmd, .act_sel, .def_mode, .word_index, .value,
		.lo0(lo0_q), .hi0(hi0_q), .lo1(lo1_q), .hi1(hi1_q), .st,
		.res_valid(done), .res_index(action_index), .res_action(action),
		.res_sample(nearest_sample), .res_default(used_default),
		.res_last(last_result)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && last_result |=> !done) else $error("extra result");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> busy) else $error("emit while idle");
	a_def_sample: assert property (@(posedge clk) disable iff (!arst_n)
		done && used_default |-> nearest_sample == 6'd0) else $error("bad default");

endmodule
`default_nettype wire
